### hdl/pgc_pkg.sv
// ----------------------------------------------------------------------------
// pgc_pkg
// Shared types and constants for the palette gradient colorizer.
// ----------------------------------------------------------------------------
package pgc_pkg;

    localparam int MAX_ITER_W = 16;
    localparam int COUNT_W    = 4;
    localparam int CH_W       = 8;
    localparam int COLOR_W    = 3 * CH_W;
    localparam int PAIR_W     = 2 * COLOR_W;
    localparam int CFG_W      = PAIR_W;
    localparam int CFG_IDX_W  = 3;
    localparam int PAL_SIZE   = 8;
    localparam int PAL_IDX_W  = 3;
    localparam int PAIR_REGS  = PAL_SIZE / 2;

    localparam logic [COUNT_W-1:0]    COLOR_COUNT_RST = 4'd2;
    localparam logic [MAX_ITER_W-1:0] MAX_ITER_RST    = 16'd256;
    localparam logic [PAIR_W-1:0]     PAIR_01_RST     = 48'hFFFFFF000000;
    localparam logic [PAIR_W-1:0]     PAIR_RST        = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_COUNT    = 3'd0,
        REG_MAX_ITERATIONS = 3'd1,
        REG_SMOOTH_MODE    = 3'd2,
        REG_PAIR_01        = 3'd3,
        REG_PAIR_23        = 3'd4,
        REG_PAIR_45        = 3'd5,
        REG_PAIR_67        = 3'd6
    } cfg_reg_t;

    typedef logic [PAL_SIZE-1:0][COLOR_W-1:0] palette_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic vld;
        logic sat;
    } div_ctl_t;

endpackage

### hdl/pgc_iter_if.sv
// ----------------------------------------------------------------------------
// pgc_iter_if
// Valid/ready channel carrying one pixel's iteration count per item.
// ----------------------------------------------------------------------------
interface pgc_iter_if #(
    parameter int ITER_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [ITER_BITS-1:0] iterations;

    modport source (output valid, output iterations, input ready);
    modport sink   (input valid, input iterations, output ready);
endinterface

### hdl/pgc_rgb_if.sv
// ----------------------------------------------------------------------------
// pgc_rgb_if
// Valid/ready channel carrying one RGB pixel per item.
// ----------------------------------------------------------------------------
interface pgc_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### hdl/pgc_div_stage.sv
// ----------------------------------------------------------------------------
// pgc_div_stage
// One registered step of the restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
module pgc_div_stage
    import pgc_pkg::*;
#(
    parameter int QB = 19
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [MAX_ITER_W-1:0] divisor,
    input  div_ctl_t              ctl_in,
    input  logic [MAX_ITER_W-1:0] rem_in,
    input  logic [QB-1:0]         qd_in,
    output div_ctl_t              ctl_out,
    output logic [MAX_ITER_W-1:0] rem_out,
    output logic [QB-1:0]         qd_out
);

    div_ctl_t              ctl_reg;
    logic [MAX_ITER_W-1:0] rem_reg;
    logic [QB-1:0]         qd_reg;

    logic [MAX_ITER_W:0]   acc;
    logic [MAX_ITER_W:0]   diff;
    logic                  ge;
    logic [MAX_ITER_W-1:0] rem_next;
    logic [QB-1:0]         qd_next;

    always_comb
    begin
        acc      = {rem_in, qd_in[QB-1]};
        diff     = acc - {1'b0, divisor};
        ge       = (acc >= {1'b0, divisor});
        rem_next = ge ? diff[MAX_ITER_W-1:0] : acc[MAX_ITER_W-1:0];
        qd_next  = {qd_in[QB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            qd_reg  <= qd_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign qd_out  = qd_reg;

endmodule

### hdl/pgc_smooth.sv
// ----------------------------------------------------------------------------
// pgc_smooth
// Three-stage weight pipeline: t^2, then t^3 and the quintic factor, then
// the smoothstep product, or t itself in linear mode.
// ----------------------------------------------------------------------------
module pgc_smooth
    import pgc_pkg::*;
#(
    parameter int SEG_BITS  = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 smooth_mode,
    input  logic                 vld_in,
    input  logic [SEG_BITS-1:0]  seg_in,
    input  logic [FRAC_BITS:0]   t_in,
    output logic                 vld_out,
    output logic [SEG_BITS-1:0]  seg_out,
    output logic [FRAC_BITS:0]   w_out
);

    localparam int TW   = FRAC_BITS + 1;
    localparam int SQ_W = 2 * TW;
    localparam int PW   = FRAC_BITS + 5;
    localparam int WP_W = TW + PW;
    localparam int WQ_W = WP_W - FRAC_BITS;

    localparam logic [SQ_W-1:0] HALF_SQ = SQ_W'(1) << (FRAC_BITS - 1);
    localparam logic [WP_W-1:0] HALF_WP = WP_W'(1) << (FRAC_BITS - 1);
    localparam logic [TW-1:0]   ONE_T   = TW'(1) << FRAC_BITS;
    localparam logic [PW-1:0]   TEN_ONE = (PW'(1) << (FRAC_BITS + 3)) + (PW'(1) << (FRAC_BITS + 1));

    logic                a_vld_reg;
    logic [SEG_BITS-1:0] a_seg_reg;
    logic [TW-1:0]       a_t_reg;
    logic [TW-1:0]       a_t2_reg;

    logic                b_vld_reg;
    logic [SEG_BITS-1:0] b_seg_reg;
    logic [TW-1:0]       b_t_reg;
    logic [TW-1:0]       b_t3_reg;
    logic [PW-1:0]       b_p_reg;

    logic                c_vld_reg;
    logic [SEG_BITS-1:0] c_seg_reg;
    logic [TW-1:0]       c_w_reg;

    logic [SQ_W-1:0] sq_a;
    logic [TW-1:0]   t2_next;
    logic [SQ_W-1:0] sq_b;
    logic [TW-1:0]   t3_next;
    logic [PW-1:0]   p_pos;
    logic [PW-1:0]   p_neg;
    logic [PW-1:0]   p_next;
    logic [WP_W-1:0] wp;
    logic [WQ_W-1:0] wq;
    logic [TW-1:0]   ws;
    logic [TW-1:0]   w_next;

    always_comb
    begin
        sq_a    = SQ_W'(t_in) * SQ_W'(t_in) + HALF_SQ;
        t2_next = sq_a[FRAC_BITS +: TW];

        sq_b    = SQ_W'(a_t2_reg) * SQ_W'(a_t_reg) + HALF_SQ;
        t3_next = sq_b[FRAC_BITS +: TW];
        p_pos   = (PW'(a_t2_reg) << 2) + (PW'(a_t2_reg) << 1) + TEN_ONE;
        p_neg   = (PW'(a_t_reg) << 4) - PW'(a_t_reg);
        p_next  = (p_pos >= p_neg) ? (p_pos - p_neg) : '0;

        wp      = WP_W'(b_t3_reg) * WP_W'(b_p_reg) + HALF_WP;
        wq      = wp[WP_W-1:FRAC_BITS];
        ws      = (wq > WQ_W'(ONE_T)) ? ONE_T : wq[TW-1:0];
        w_next  = smooth_mode ? ws : b_t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= vld_in;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_seg_reg <= seg_in;
            a_t_reg   <= t_in;
            a_t2_reg  <= t2_next;
            b_seg_reg <= a_seg_reg;
            b_t_reg   <= a_t_reg;
            b_t3_reg  <= t3_next;
            b_p_reg   <= p_next;
            c_seg_reg <= b_seg_reg;
            c_w_reg   <= w_next;
        end
    end

    assign vld_out = c_vld_reg;
    assign seg_out = c_seg_reg;
    assign w_out   = c_w_reg;

endmodule

### hdl/pgc_blend.sv
// ----------------------------------------------------------------------------
// pgc_blend
// Palette pair select and two-stage per-channel blend with round to nearest.
// ----------------------------------------------------------------------------
module pgc_blend
    import pgc_pkg::*;
#(
    parameter int SEG_BITS  = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  palette_t            palette,
    input  logic                vld_in,
    input  logic [SEG_BITS-1:0] seg_in,
    input  logic [FRAC_BITS:0]  w_in,
    output logic                vld_out,
    output rgb_t                rgb_out
);

    localparam int TW     = FRAC_BITS + 1;
    localparam int PROD_W = TW + CH_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [TW-1:0]    ONE_T = TW'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0] HALF  = SUM_W'(1) << (FRAC_BITS - 1);

    logic [PAL_SIZE-1:0][PAIR_W-1:0] seg_pairs;
    logic [PAIR_W-1:0]               pair_sel;
    logic [COLOR_W-1:0]              color_a;
    logic [COLOR_W-1:0]              color_b;
    logic [TW-1:0]                   w_inv;

    logic                            p_vld_reg;
    logic [PROD_W-1:0]               prod_a_reg [3];
    logic [PROD_W-1:0]               prod_b_reg [3];
    logic                            s_vld_reg;
    logic [CH_W-1:0]                 ch_reg [3];

    for (genvar k = 0; k < PAL_SIZE; k++)
    begin : g_pair
        assign seg_pairs[k] = {palette[(k + 1) % PAL_SIZE], palette[k]};
    end

    always_comb
    begin
        pair_sel = seg_pairs[PAL_IDX_W'(seg_in)];
        color_a  = pair_sel[COLOR_W-1:0];
        color_b  = pair_sel[PAIR_W-1:COLOR_W];
        w_inv    = ONE_T - w_in;
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_ch
        localparam int SH = COLOR_W - CH_W * (ch + 1);

        logic [PROD_W-1:0] prod_a_next;
        logic [PROD_W-1:0] prod_b_next;
        logic [SUM_W-1:0]  sum;

        always_comb
        begin
            prod_a_next = PROD_W'(color_a[SH +: CH_W]) * PROD_W'(w_inv);
            prod_b_next = PROD_W'(color_b[SH +: CH_W]) * PROD_W'(w_in);
            sum         = SUM_W'(prod_a_reg[ch]) + SUM_W'(prod_b_reg[ch]) + HALF;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_a_reg[ch] <= prod_a_next;
                prod_b_reg[ch] <= prod_b_next;
                ch_reg[ch]     <= sum[FRAC_BITS +: CH_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg <= vld_in;
            s_vld_reg <= p_vld_reg;
        end
    end

    assign vld_out       = s_vld_reg;
    assign rgb_out.red   = ch_reg[0];
    assign rgb_out.green = ch_reg[1];
    assign rgb_out.blue  = ch_reg[2];

endmodule

### hdl/palette_gradient_colorizer.sv
// ----------------------------------------------------------------------------
// palette_gradient_colorizer
// Maps escape-iteration counts to RGB along a piecewise linear or smoothstep
// palette gradient.
//
//   channel   dir  payload                  handshake
//   pix_in    in   iterations               valid / ready
//   pix_out   out  red, green, blue         valid / ready
//   cfg       in   cfg_index, cfg_data      cfg_we, no back-pressure
//
// One item per cycle sustained while the output skid stage is empty. Items
// pass the input register, the restoring divider (one quotient bit per stage),
// the smoothing and blend stages and the output register. Reset clears all
// valid bits and loads the register defaults. The pipeline freezes only while
// the output skid stage is full; pix_in.ready is the skid stage being empty.
// ----------------------------------------------------------------------------
module palette_gradient_colorizer
    import pgc_pkg::*;
#(
    parameter int MAX_COLORS = 8,
    parameter int ITER_BITS  = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pgc_iter_if.sink             pix_in,
    pgc_rgb_if.source            pix_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SEG_BITS = $clog2(MAX_COLORS);
    localparam int QB       = SEG_BITS + FRAC_BITS;
    localparam int NUM_W    = MAX_ITER_W + SEG_BITS;
    localparam int CMP_W    = (ITER_BITS > MAX_ITER_W) ? ITER_BITS : MAX_ITER_W;
    localparam int TW       = FRAC_BITS + 1;

    localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;

    logic [COUNT_W-1:0]    color_count_reg;
    logic [MAX_ITER_W-1:0] max_iter_reg;
    logic                  smooth_mode_reg;
    logic [PAIR_W-1:0]     pair_reg [PAIR_REGS];

    palette_t              palette;
    logic [COUNT_W-1:0]    n_clamped;
    logic [SEG_BITS-1:0]   n_m1;
    logic [SEG_BITS-1:0]   n_m2;
    logic [MAX_ITER_W-1:0] m_eff;

    logic                  en;
    logic                  sat_in;
    logic [MAX_ITER_W-1:0] c_clamped;
    logic [NUM_W-1:0]      num;

    div_ctl_t              s0_ctl_reg;
    logic [MAX_ITER_W-1:0] s0_rem_reg;
    logic [QB-1:0]         s0_qd_reg;

    div_ctl_t              div_ctl [QB+1];
    logic [MAX_ITER_W-1:0] div_rem [QB+1];
    logic [QB-1:0]         div_qd  [QB+1];

    logic [SEG_BITS-1:0]   seg_q;
    logic [SEG_BITS-1:0]   seg_fin;
    logic [TW-1:0]         t_fin;

    logic                  sm_vld;
    logic [SEG_BITS-1:0]   sm_seg;
    logic [TW-1:0]         sm_w;

    logic                  bl_vld;
    rgb_t                  bl_rgb;
    logic                  push;

    logic                  out_valid_reg;
    rgb_t                  out_rgb_reg;
    logic                  skid_valid_reg;
    rgb_t                  skid_rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_count_reg <= COLOR_COUNT_RST;
            max_iter_reg    <= MAX_ITER_RST;
            smooth_mode_reg <= 1'b0;
            pair_reg[0]     <= PAIR_01_RST;
            pair_reg[1]     <= PAIR_RST;
            pair_reg[2]     <= PAIR_RST;
            pair_reg[3]     <= PAIR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COLOR_COUNT:    color_count_reg <= cfg_data[COUNT_W-1:0];
                REG_MAX_ITERATIONS: max_iter_reg    <= cfg_data[MAX_ITER_W-1:0];
                REG_SMOOTH_MODE:    smooth_mode_reg <= cfg_data[0];
                REG_PAIR_01:        pair_reg[0]     <= cfg_data[PAIR_W-1:0];
                REG_PAIR_23:        pair_reg[1]     <= cfg_data[PAIR_W-1:0];
                REG_PAIR_45:        pair_reg[2]     <= cfg_data[PAIR_W-1:0];
                REG_PAIR_67:        pair_reg[3]     <= cfg_data[PAIR_W-1:0];
                default:            ;
            endcase
        end
    end

    for (genvar k = 0; k < PAL_SIZE; k++)
    begin : g_pal
        assign palette[k] = pair_reg[k / 2][(k % 2) * COLOR_W +: COLOR_W];
    end

    always_comb
    begin
        priority if (color_count_reg < COUNT_W'(2))
            n_clamped = COUNT_W'(2);
        else if (color_count_reg > COUNT_W'(MAX_COLORS))
            n_clamped = COUNT_W'(MAX_COLORS);
        else
            n_clamped = color_count_reg;
        n_m1  = SEG_BITS'(n_clamped - COUNT_W'(1));
        n_m2  = SEG_BITS'(n_clamped - COUNT_W'(2));
        m_eff = (max_iter_reg == '0) ? MAX_ITER_W'(1) : max_iter_reg;
    end

    assign en           = !skid_valid_reg;
    assign pix_in.ready = en;

    always_comb
    begin
        sat_in    = (CMP_W'(pix_in.iterations) >= CMP_W'(m_eff));
        c_clamped = sat_in ? m_eff : MAX_ITER_W'(pix_in.iterations);
        num       = NUM_W'(c_clamped) * NUM_W'(n_m1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else if (en)
        begin
            s0_ctl_reg.vld <= pix_in.valid;
            s0_ctl_reg.sat <= sat_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_rem_reg <= num[NUM_W-1:SEG_BITS];
            s0_qd_reg  <= {num[SEG_BITS-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    assign div_ctl[0] = s0_ctl_reg;
    assign div_rem[0] = s0_rem_reg;
    assign div_qd[0]  = s0_qd_reg;

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        pgc_div_stage #(
            .QB (QB)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .divisor (m_eff),
            .ctl_in  (div_ctl[i]),
            .rem_in  (div_rem[i]),
            .qd_in   (div_qd[i]),
            .ctl_out (div_ctl[i+1]),
            .rem_out (div_rem[i+1]),
            .qd_out  (div_qd[i+1])
        );
    end

    always_comb
    begin
        seg_q   = div_qd[QB][QB-1:FRAC_BITS];
        seg_fin = div_ctl[QB].sat ? n_m2 : seg_q;
        t_fin   = div_ctl[QB].sat ? ONE_T : {1'b0, div_qd[QB][FRAC_BITS-1:0]};
    end

    pgc_smooth #(
        .SEG_BITS  (SEG_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_smooth (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .smooth_mode (smooth_mode_reg),
        .vld_in      (div_ctl[QB].vld),
        .seg_in      (seg_fin),
        .t_in        (t_fin),
        .vld_out     (sm_vld),
        .seg_out     (sm_seg),
        .w_out       (sm_w)
    );

    pgc_blend #(
        .SEG_BITS  (SEG_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .palette (palette),
        .vld_in  (sm_vld),
        .seg_in  (sm_seg),
        .w_in    (sm_w),
        .vld_out (bl_vld),
        .rgb_out (bl_rgb)
    );

    assign push = en && bl_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pix_out.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pix_out.ready)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pix_out.ready)
            begin
                out_rgb_reg <= skid_rgb_reg;
            end
        end
        else if (!out_valid_reg || pix_out.ready)
        begin
            if (push)
            begin
                out_rgb_reg <= bl_rgb;
            end
        end
        else if (push)
        begin
            skid_rgb_reg <= bl_rgb;
        end
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.red   = out_rgb_reg.red;
    assign pix_out.green = out_rgb_reg.green;
    assign pix_out.blue  = out_rgb_reg.blue;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !pix_out.ready))
        else $error("skid stage filled without a stalled output");

    a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (div_ctl[QB].vld && !div_ctl[QB].sat) |-> (seg_q < n_m1))
        else $error("divider segment index beyond the last interval");

endmodule
